/* rtl/msrps_pkg.sv */
// Package for the multi-servo ramp pulse sequencer: item layouts, codes,
// register map and reset constants. No dependencies.
package msrps_pkg;

  // widths fixed by the item fields and registers
  localparam int unsigned POS_W   = 16;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned IN_DW   = 24;
  localparam int unsigned OUT_DW  = 24;

  // register reset values
  localparam logic [POS_W-1:0]  FRAME_RST    = 16'd40000;
  localparam logic [STEP_W-1:0] STEP_RST     = 10'd27;
  localparam logic [POS_W-1:0]  PAIR_SUM_RST = 16'd6162;
  localparam logic [POS_W-1:0]  CLAMP_LO_RST = 16'd1000;
  localparam logic [POS_W-1:0]  CLAMP_HI_RST = 16'd5000;

  // position and target reset values
  localparam logic [POS_W-1:0]  POS0_RST     = 16'd3162;
  localparam logic [POS_W-1:0]  POSN_RST     = 16'd3000;

  // highest joint number that maps to a channel
  localparam logic [2:0]        JOINT_MAX    = 3'd6;

  // item kind carried in the slave-side tuser
  typedef enum logic [1:0] {
    FUNC_SLOT = 2'd0,
    FUNC_RAMP = 2'd1,
    FUNC_SET  = 2'd2
  } func_e;

  // register index, byte address divided by four
  typedef enum logic [2:0] {
    REG_FRAME    = 3'd0,
    REG_STEP     = 3'd1,
    REG_PAIR_SUM = 3'd2,
    REG_CLAMP_LO = 3'd3,
    REG_CLAMP_HI = 3'd4
  } reg_e;

  // slave-side tdata layout, last field lowest
  typedef struct packed {
    logic [4:0]       pad;
    logic [POS_W-1:0] joint_value;
    logic [2:0]       joint_index;
  } in_data_t;

  // master-side tdata layout, last field lowest
  typedef struct packed {
    logic              done_res;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        shift_clocks;
    logic              inject_one;
    logic [POS_W-1:0]  interval;
  } res_t;

endpackage

/* rtl/msrps_lane.sv */
// One channel of the slew ramp: steps a position toward its target and flags
// when it lands within one step. Depends on msrps_pkg.
module msrps_lane (
  input  logic [msrps_pkg::POS_W-1:0]  pos_i,
  input  logic [msrps_pkg::POS_W-1:0]  tgt_i,
  input  logic [msrps_pkg::STEP_W-1:0] step_i,
  output logic [msrps_pkg::POS_W-1:0]  pos_o,
  output logic                         near_o
);
  import msrps_pkg::*;

  logic [POS_W-1:0] step16;
  logic [POS_W-1:0] pos_dn;
  logic [POS_W-1:0] pos_up;
  logic [POS_W-1:0] diff;

  assign step16 = POS_W'(step_i);

  // move down if above, then up if below, both wrapping
  assign pos_dn = (pos_i > tgt_i) ? pos_i - step16 : pos_i;
  assign pos_up = (pos_dn < tgt_i) ? pos_dn + step16 : pos_dn;

  // distance to target after the move
  assign diff   = (pos_up > tgt_i) ? pos_up - tgt_i : tgt_i - pos_up;

  assign pos_o  = pos_up;
  assign near_o = diff < step16;

endmodule

/* rtl/multi_servo_ramp_pulse_sequencer_unit.sv */
// Top level of the multi-servo ramp pulse sequencer: item handshakes, APB
// registers, channel state and result register. Depends on msrps_pkg, msrps_lane.
//
//  channel   direction  fields
//  s_axis    in         tuser: func; tdata: joint_index, joint_value
//  m_axis    out        tdata: interval, inject_one, shift_clocks, slot, done_res
//  apb       in/out     frame_period, step_size, pair_sum, clamp_low, clamp_high
//
// One item is taken per cycle while s_axis_tready is high; its result sits in
// the output register from the cycle after acceptance. A single result register
// follows the ramp lanes.
// s_axis_tready is high whenever the result register is empty or being taken.
// After reset all positions and targets hold their start values, no clearing pass.
module multi_servo_ramp_pulse_sequencer_unit #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [1:0]                    s_axis_tuser,  // [1:0] func
  input  logic [msrps_pkg::IN_DW-1:0]   s_axis_tdata,  // [2:0] joint_index, [18:3] joint_value
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] interval, [16] inject_one, [18:17] shift_clocks, [22:19] slot, [23] done_res
  output logic [msrps_pkg::OUT_DW-1:0]  m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msrps_pkg::APB_AW-1:0]  paddr,
  input  logic [msrps_pkg::APB_DW-1:0]  pwdata,
  output logic [msrps_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import msrps_pkg::*;

  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(CHANNELS + 1);
  localparam int unsigned SUM_W = POS_W + $clog2(CHANNELS);
  localparam int unsigned RST_SUM = 32'(POS0_RST) + 32'(POSN_RST) * (CHANNELS - 1);
  localparam logic [POS_W-1:0] GAP_RST =
    (RST_SUM >= 32'(FRAME_RST)) ? '0 : POS_W'(32'(FRAME_RST) - RST_SUM);
  localparam logic [SLOT_W-1:0] GAP_SLOT = SLOT_W'(CHANNELS);
  localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(CHANNELS);

  // configuration registers
  logic [POS_W-1:0]  frame_q, pair_sum_q, clamp_lo_q, clamp_hi_q;
  logic [STEP_W-1:0] step_q;
  logic              cfg_we;
  reg_e              cfg_idx;

  // channel state
  logic [POS_W-1:0] pos_q [CHANNELS];
  logic [POS_W-1:0] pos_d [CHANNELS];
  logic [POS_W-1:0] tgt_q [CHANNELS];
  logic [POS_W-1:0] tgt_d [CHANNELS];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] gap_q, gap_d;

  // result register
  logic m_valid_q;
  res_t res_q, res_d;

  // item decode
  logic     in_fire;
  func_e    func;
  in_data_t in_data;

  // ramp lanes
  logic [POS_W-1:0] lane_pos  [CHANNELS];
  logic [POS_W-1:0] ramp_pos  [CHANNELS];
  logic [CHANNELS-1:0] lane_near;
  logic                all_near;
  logic [SUM_W-1:0]    pos_sum;
  logic [POS_W-1:0]    gap_new;

  // set target
  logic [POS_W-1:0] v_lo, v_clamp;
  logic [2:0]       ch_full;
  logic [CH_W-1:0]  ch_idx;
  logic             set_ok;

  // ---------------------------------------------------------------------
  // APB register port
  assign pready  = 1'b1;
  assign cfg_idx = reg_e'(paddr[4:2]);
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q    <= FRAME_RST;
      step_q     <= STEP_RST;
      pair_sum_q <= PAIR_SUM_RST;
      clamp_lo_q <= CLAMP_LO_RST;
      clamp_hi_q <= CLAMP_HI_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FRAME:    frame_q    <= pwdata[POS_W-1:0];
        REG_STEP:     step_q     <= pwdata[STEP_W-1:0];
        REG_PAIR_SUM: pair_sum_q <= pwdata[POS_W-1:0];
        REG_CLAMP_LO: clamp_lo_q <= pwdata[POS_W-1:0];
        REG_CLAMP_HI: clamp_hi_q <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_FRAME:    prdata = APB_DW'(frame_q);
      REG_STEP:     prdata = APB_DW'(step_q);
      REG_PAIR_SUM: prdata = APB_DW'(pair_sum_q);
      REG_CLAMP_LO: prdata = APB_DW'(clamp_lo_q);
      REG_CLAMP_HI: prdata = APB_DW'(clamp_hi_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // handshake
  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign func          = func_e'(s_axis_tuser);
  assign in_data       = in_data_t'(s_axis_tdata);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res_q;

  // ---------------------------------------------------------------------
  // ramp lanes, one per channel
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    msrps_lane u_lane (
      .pos_i  (pos_q[g]),
      .tgt_i  (tgt_q[g]),
      .step_i (step_q),
      .pos_o  (lane_pos[g]),
      .near_o (lane_near[g])
    );
  end

  assign all_near = &lane_near;

  // positions after snap, and their sum for the frame gap
  always_comb begin
    pos_sum = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      ramp_pos[i] = all_near ? tgt_q[i] : lane_pos[i];
      pos_sum     = pos_sum + SUM_W'(ramp_pos[i]);
    end
  end

  assign gap_new = (pos_sum >= SUM_W'(frame_q)) ? '0 : frame_q - pos_sum[POS_W-1:0];

  // ---------------------------------------------------------------------
  // set target: clamp and map joint to channel
  assign v_lo    = (in_data.joint_value < clamp_lo_q) ? clamp_lo_q : in_data.joint_value;
  assign v_clamp = (v_lo > clamp_hi_q) ? clamp_hi_q : v_lo;
  assign ch_full = (in_data.joint_index == '0) ? 3'd0 : in_data.joint_index + 3'd1;
  assign ch_idx  = CH_W'(ch_full);
  assign set_ok  = (in_data.joint_index <= JOINT_MAX) && (32'(ch_full) < CHANNELS) &&
                   (v_clamp != '0) && (v_clamp != tgt_q[ch_idx]);

  // ---------------------------------------------------------------------
  // next state and result
  always_comb begin
    pos_d = pos_q;
    tgt_d = tgt_q;
    cnt_d = cnt_q;
    gap_d = gap_q;
    res_d = '0;
    if (in_fire) begin
      unique case (func)
        FUNC_SLOT: begin
          res_d.inject_one   = (cnt_q == '0);
          res_d.shift_clocks = (cnt_q == '0) ? 2'd2 : 2'd1;
          if (cnt_q >= CNT_END) begin
            res_d.interval = gap_q;
            res_d.slot     = GAP_SLOT;
            cnt_d          = '0;
          end else begin
            res_d.interval = pos_q[cnt_q[CH_W-1:0]];
            res_d.slot     = SLOT_W'(cnt_q);
            cnt_d          = cnt_q + CNT_W'(1);
          end
        end
        FUNC_RAMP: begin
          pos_d          = ramp_pos;
          gap_d          = gap_new;
          res_d.done_res = all_near;
        end
        FUNC_SET: begin
          if (set_ok) begin
            tgt_d[ch_idx] = v_clamp;
            if (ch_full == 3'd0) begin
              tgt_d[1] = pair_sum_q - v_clamp;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_q[i] <= (i == 0) ? POS0_RST : POSN_RST;
        tgt_q[i] <= (i == 0) ? POS0_RST : POSN_RST;
      end
      cnt_q     <= '0;
      gap_q     <= GAP_RST;
      m_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      tgt_q <= tgt_d;
      cnt_q <= cnt_d;
      gap_q <= gap_d;
      if (in_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded on each accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

endmodule

/* rtl/msrps_checker.sv */
// Port-level checks for the multi-servo ramp pulse sequencer, bound to the
// top level. Depends on msrps_pkg.
module msrps_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [1:0]                   s_axis_tuser,  // [1:0] func
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  // [15:0] interval, [16] inject_one, [18:17] shift_clocks, [22:19] slot, [23] done_res
  input logic [msrps_pkg::OUT_DW-1:0] m_axis_tdata
);
  import msrps_pkg::*;

  res_t res;
  logic in_fire;

  assign res     = res_t'(m_axis_tdata);
  assign in_fire = s_axis_tvalid & s_axis_tready;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a slot event gives a result with one or two shift clocks next cycle
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser == FUNC_SLOT |=>
      m_axis_tvalid && (res.shift_clocks == 2'd1 || res.shift_clocks == 2'd2))
    else $error("slot event without shift clocks");

  // other items give no slot fields
  a_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser != FUNC_SLOT |=>
      m_axis_tvalid && res.shift_clocks == 2'd0 && !res.inject_one && res.slot == '0 &&
      res.interval == '0)
    else $error("slot fields set for a non-slot item");

  // the token bit is injected only at the start of a frame
  a_inject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.inject_one |-> res.shift_clocks == 2'd2 && res.slot == '0 &&
      !res.done_res)
    else $error("token injected outside frame start");

endmodule

bind multi_servo_ramp_pulse_sequencer_unit msrps_checker u_msrps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
